>>> hw/rtl/charger_protection_monitor_macros.svh
// Assertion macros for the charger protection monitor checker.
// Clocked on clock; assertions are disabled while reset is high.
`ifndef CHARGER_PROTECTION_MONITOR_MACROS_SVH
`define CHARGER_PROTECTION_MONITOR_MACROS_SVH

// Same-cycle implication.
`define CPM_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/cpm_pkg.sv
// Shared constants, register indexes and types of the charger protection monitor.
// No dependencies; used by the interfaces, cpm_scale, the top level and the checker.
package cpm_pkg;

   // Boxcar window depths (1..16 each)
   localparam int VOLT_WINDOW  = 16;
   localparam int CURR_WINDOW  = 16;
   localparam int SHORT_WINDOW = 8;

   localparam int VOLT_PTR_W  = (VOLT_WINDOW > 1) ? $clog2(VOLT_WINDOW) : 1;
   localparam int CURR_PTR_W  = (CURR_WINDOW > 1) ? $clog2(CURR_WINDOW) : 1;
   localparam int SHORT_PTR_W = (SHORT_WINDOW > 1) ? $clog2(SHORT_WINDOW) : 1;

   // Field widths
   localparam int SAMPLE_W  = 12;
   localparam int GAIN_W    = 16;
   localparam int THRESH_W  = 12;
   localparam int HOURS_W   = 8;
   localparam int MS_W      = 10;
   localparam int SEC_W     = 6;
   localparam int MIN_W     = 6;
   localparam int SUM_W     = 16;
   localparam int MV_W      = 16;
   localparam int COARSE_W  = 13;
   localparam int PROD_W    = SAMPLE_W + GAIN_W;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_MONITOR_ENABLE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_VOLTAGE_GAIN      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CURRENT_GAIN      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_THRESHOLD   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_UNDER_VOLT_THRESH = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT_HOURS     = 3'd5;

   localparam logic [GAIN_W-1:0]   VOLTAGE_GAIN_RST  = 16'd1000;
   localparam logic [GAIN_W-1:0]   CURRENT_GAIN_RST  = 16'd1000;
   localparam logic [THRESH_W-1:0] SHORT_THRESH_RST  = 12'd4095;
   localparam logic [THRESH_W-1:0] UV_THRESH_RST     = 12'd0;
   localparam logic [HOURS_W-1:0]  TIMEOUT_HOURS_RST = 8'd8;

   // Charge timer
   localparam int MS_PER_SEC   = 1000;
   localparam int SEC_PER_MIN  = 60;
   localparam int MIN_PER_HOUR = 60;
   localparam logic [HOURS_W-1:0] HOURS_MAX = 8'd255;

   // Scaling: product / 1000, saturated to MV_W bits
   localparam int SCALE_DIVISOR = 1000;
   localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'((2 ** MV_W) * SCALE_DIVISOR);
   // below SAT_LIMIT: x / 1000 == ((x >> 3) * 8589935) >> 30, exact for x >> 3 < 2^23
   localparam int DIV1000_PRE_SHIFT = 3;
   localparam int DIV1000_MULT_W    = 24;
   localparam logic [DIV1000_MULT_W-1:0] DIV1000_MULT = 24'd8589935;
   localparam int DIV1000_SHIFT     = 30;
   // x / 10 == (x * 52429) >> 19, exact for x < 2^16
   localparam int COARSE_DIV     = 10;
   localparam int DIV10_MULT_W   = 16;
   localparam logic [DIV10_MULT_W-1:0] DIV10_MULT = 16'd52429;
   localparam int DIV10_SHIFT    = 19;
   localparam int SCALE_LATENCY  = 4;

   // Result buffer
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic valid;
      logic upd;
   } scale_ctl_type;

   typedef struct packed {
      logic               short_fault;
      logic               charge_timeout;
      logic [HOURS_W-1:0] elapsed_hours;
      logic [MIN_W-1:0]   elapsed_minutes;
   } status_type;

   typedef struct packed {
      logic [MV_W-1:0]     voltage_mv;
      logic [COARSE_W-1:0] voltage_coarse;
      logic [MV_W-1:0]     current_ma;
      logic [COARSE_W-1:0] current_coarse;
      status_type          stat;
   } rsp_item_type;

endpackage

>>> hw/rtl/cpm_if.sv
// Valid/ready channel interfaces of the charger protection monitor.
// Depends on cpm_pkg for field widths.
interface cpm_req_if;
   import cpm_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] voltage_sample;
   logic [SAMPLE_W-1:0] current_sample;
   logic                charging;
   logic                clear_timer;

   modport source (output valid, voltage_sample, current_sample, charging, clear_timer,
                   input ready);
   modport sink (input valid, voltage_sample, current_sample, charging, clear_timer,
                 output ready);
endinterface

interface cpm_rsp_if;
   import cpm_pkg::*;
   logic                valid;
   logic                ready;
   logic [MV_W-1:0]     voltage_mv;
   logic [COARSE_W-1:0] voltage_coarse;
   logic [MV_W-1:0]     current_ma;
   logic [COARSE_W-1:0] current_coarse;
   logic                short_fault;
   logic                charge_timeout;
   logic [HOURS_W-1:0]  elapsed_hours;
   logic [MIN_W-1:0]    elapsed_minutes;

   modport source (output valid, voltage_mv, voltage_coarse, current_ma, current_coarse,
                   short_fault, charge_timeout, elapsed_hours, elapsed_minutes,
                   input ready);
   modport sink (input valid, voltage_mv, voltage_coarse, current_ma, current_coarse,
                 short_fault, charge_timeout, elapsed_hours, elapsed_minutes,
                 output ready);
endinterface

>>> hw/rtl/cpm_scale.sv
// Gain scaling pipeline: average * gain / 1000 saturated, then tenths; holds last value.
// Depends on cpm_pkg. One item per cycle.
module cpm_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  cpm_pkg::scale_ctl_type        ctl_in,
   input  logic [cpm_pkg::SAMPLE_W-1:0]  avg,
   input  logic [cpm_pkg::GAIN_W-1:0]    gain,
   output logic [cpm_pkg::MV_W-1:0]      scaled,
   output logic [cpm_pkg::COARSE_W-1:0]  coarse
);
   import cpm_pkg::*;

   localparam int QUO_IN_W     = PROD_W - DIV1000_PRE_SHIFT;
   localparam int RECIP_PROD_W = QUO_IN_W + DIV1000_MULT_W;
   localparam int TENTH_PROD_W = MV_W + DIV10_MULT_W;

   scale_ctl_type           ctl_a_ff;
   scale_ctl_type           ctl_b_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic                    sat_ff;
   logic [MV_W-1:0]         quo_ff;
   logic [RECIP_PROD_W-1:0] recip_prod;
   logic [MV_W-1:0]         mv_in;
   logic [MV_W-1:0]         mv_ff;
   logic [MV_W-1:0]         hold_ff;
   logic [MV_W-1:0]         out_ff;
   logic [TENTH_PROD_W-1:0] tenth_prod;
   logic [COARSE_W-1:0]     coarse_ff;

   assign recip_prod = RECIP_PROD_W'(prod_ff[PROD_W-1:DIV1000_PRE_SHIFT])
                       * RECIP_PROD_W'(DIV1000_MULT);

   // items that do not update repeat the last held value
   assign mv_in = ctl_b_ff.upd ? (sat_ff ? '1 : quo_ff) : hold_ff;

   assign tenth_prod = TENTH_PROD_W'(mv_ff) * TENTH_PROD_W'(DIV10_MULT);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         hold_ff  <= '0;
      end else begin
         ctl_a_ff <= ctl_in;
         ctl_b_ff <= ctl_a_ff;
         if (ctl_b_ff.valid && ctl_b_ff.upd) begin
            hold_ff <= mv_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= PROD_W'(avg) * PROD_W'(gain);
      sat_ff    <= prod_ff >= SAT_LIMIT;
      quo_ff    <= recip_prod[DIV1000_SHIFT +: MV_W];
      mv_ff     <= mv_in;
      out_ff    <= mv_ff;
      coarse_ff <= tenth_prod[DIV10_SHIFT +: COARSE_W];
   end

   assign scaled = out_ff;
   assign coarse = coarse_ff;

endmodule

>>> hw/rtl/charger_protection_monitor.sv
// Charger protection monitor top level: window memories, short check, charge timer,
// result buffer. Depends on cpm_pkg, cpm_req_if, cpm_rsp_if and cpm_scale.
//
//   channel   dir   handshake      carries
//   req_ch    in    valid/ready    voltage/current sample, charging, clear_timer
//   rsp_ch    out   valid/ready    scaled averages, tenths, fault, timeout, hours, minutes
//   csr_*     in    csr_we only    register index and write data
//
// One item per cycle sustained while req_ch ready is high.
// The rate is set by the window read/modify/write loop: each window memory is
// read in the cycle before use at the next position, written back in the same cycle
// the running sum is updated. No clearing pass: a fill flag per window stands in
// for the zeroed entries after reset. Up to 8 items may be outstanding; req_ch
// ready drops only when 8 results are accepted and not yet taken.
module charger_protection_monitor (
   input  logic                            clock,
   input  logic                            reset,
   cpm_req_if.sink                         req_ch,
   cpm_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [cpm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cpm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cpm_pkg::*;

   // configuration
   logic                monitor_enable_ff;
   logic [GAIN_W-1:0]   voltage_gain_ff;
   logic [GAIN_W-1:0]   current_gain_ff;
   logic [THRESH_W-1:0] short_thresh_ff;
   logic [THRESH_W-1:0] uv_thresh_ff;
   logic [HOURS_W-1:0]  timeout_hours_ff;

   // accept stage
   logic                req_fire;
   logic                rsp_fire;
   logic [PEND_W-1:0]   pending_ff;
   logic                s1_valid_ff;
   logic [SAMPLE_W-1:0] s1_vs_ff;
   logic [SAMPLE_W-1:0] s1_cs_ff;
   logic                s1_chg_ff;
   logic                s1_clr_ff;

   // window memories
   logic [SAMPLE_W-1:0] volt_mem  [VOLT_WINDOW];
   logic [SAMPLE_W-1:0] curr_mem  [CURR_WINDOW];
   logic [SAMPLE_W-1:0] short_mem [SHORT_WINDOW];

   logic [VOLT_PTR_W-1:0]  volt_pos_ff,  volt_pos_in;
   logic [CURR_PTR_W-1:0]  curr_pos_ff,  curr_pos_in;
   logic [SHORT_PTR_W-1:0] short_pos_ff, short_pos_in;
   logic [SUM_W-1:0]       volt_sum_ff,  volt_sum_in;
   logic [SUM_W-1:0]       curr_sum_ff,  curr_sum_in;
   logic [SUM_W-1:0]       short_sum_ff, short_sum_in;
   logic                   volt_full_ff, volt_full_in;
   logic                   curr_full_ff, curr_full_in;
   logic                   short_full_ff, short_full_in;
   logic [SAMPLE_W-1:0]    volt_rd_ff, curr_rd_ff, short_rd_ff;
   logic                   volt_fwd_ff, curr_fwd_ff, short_fwd_ff;
   logic [SAMPLE_W-1:0]    fwd_data_v_ff, fwd_data_c_ff;
   logic [SAMPLE_W-1:0]    volt_old, curr_old, short_old;
   logic                   volt_wrap, curr_wrap, short_wrap;
   logic [SUM_W-1:0]       short_avg;

   // fault and timer
   logic                upd;
   logic                win_we;
   logic                fault_hit;
   logic                timer_go;
   logic                fault_ff, fault_in;
   logic [MS_W-1:0]     ms_ff, ms_in;
   logic [SEC_W-1:0]    sec_ff, sec_in;
   logic [MIN_W-1:0]    min_ff, min_in;
   logic [HOURS_W-1:0]  hour_ff, hour_in;
   logic                timeout_ff, timeout_in;

   // scaling stage
   scale_ctl_type       s2_ctl_ff;
   logic [SAMPLE_W-1:0] s2_avg_v_ff;
   logic [SAMPLE_W-1:0] s2_avg_c_ff;
   status_type          s2_stat_ff;
   status_type          stat_pipe_ff  [SCALE_LATENCY];
   logic                valid_pipe_ff [SCALE_LATENCY];
   logic [MV_W-1:0]     scaled_v, scaled_c;
   logic [COARSE_W-1:0] coarse_v, coarse_c;

   // result buffer
   rsp_item_type          fifo_mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PEND_W-1:0]     fifo_cnt_ff;
   logic                  fifo_we;
   rsp_item_type          fifo_head;

   //---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         monitor_enable_ff <= 1'b0;
         voltage_gain_ff   <= VOLTAGE_GAIN_RST;
         current_gain_ff   <= CURRENT_GAIN_RST;
         short_thresh_ff   <= SHORT_THRESH_RST;
         uv_thresh_ff      <= UV_THRESH_RST;
         timeout_hours_ff  <= TIMEOUT_HOURS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MONITOR_ENABLE:    monitor_enable_ff <= csr_wdata[0];
            REG_VOLTAGE_GAIN:      voltage_gain_ff   <= csr_wdata[GAIN_W-1:0];
            REG_CURRENT_GAIN:      current_gain_ff   <= csr_wdata[GAIN_W-1:0];
            REG_SHORT_THRESHOLD:   short_thresh_ff   <= csr_wdata[THRESH_W-1:0];
            REG_UNDER_VOLT_THRESH: uv_thresh_ff      <= csr_wdata[THRESH_W-1:0];
            REG_TIMEOUT_HOURS:     timeout_hours_ff  <= csr_wdata[HOURS_W-1:0];
            default: ;
         endcase
      end
   end

   //---------------------------------------------------------------- accept
   assign req_ch.ready = pending_ff < PEND_W'(FIFO_DEPTH);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         pending_ff  <= pending_ff + PEND_W'(req_fire) - PEND_W'(rsp_fire);
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      s1_vs_ff  <= req_ch.voltage_sample;
      s1_cs_ff  <= req_ch.current_sample;
      s1_chg_ff <= req_ch.charging;
      s1_clr_ff <= req_ch.clear_timer;
   end

   //---------------------------------------------------------------- windows
   // after a fault, no later beat touches the windows or the timer
   assign upd    = monitor_enable_ff && !fault_ff;
   assign win_we = s1_valid_ff && upd;

   assign volt_wrap  = volt_pos_ff == VOLT_PTR_W'(VOLT_WINDOW - 1);
   assign curr_wrap  = curr_pos_ff == CURR_PTR_W'(CURR_WINDOW - 1);
   assign short_wrap = short_pos_ff == SHORT_PTR_W'(SHORT_WINDOW - 1);

   // entry leaving the window; zero until the window has wrapped once
   assign volt_old  = volt_fwd_ff ? fwd_data_v_ff : (volt_full_ff ? volt_rd_ff : '0);
   assign curr_old  = curr_fwd_ff ? fwd_data_c_ff : (curr_full_ff ? curr_rd_ff : '0);
   assign short_old = short_fwd_ff ? fwd_data_c_ff : (short_full_ff ? short_rd_ff : '0);

   always_comb begin
      volt_pos_in   = volt_pos_ff;
      curr_pos_in   = curr_pos_ff;
      short_pos_in  = short_pos_ff;
      volt_sum_in   = volt_sum_ff;
      curr_sum_in   = curr_sum_ff;
      short_sum_in  = short_sum_ff;
      volt_full_in  = volt_full_ff;
      curr_full_in  = curr_full_ff;
      short_full_in = short_full_ff;
      if (win_we) begin
         volt_sum_in   = volt_sum_ff - SUM_W'(volt_old) + SUM_W'(s1_vs_ff);
         curr_sum_in   = curr_sum_ff - SUM_W'(curr_old) + SUM_W'(s1_cs_ff);
         short_sum_in  = short_sum_ff - SUM_W'(short_old) + SUM_W'(s1_cs_ff);
         volt_pos_in   = volt_wrap ? '0 : volt_pos_ff + 1'b1;
         curr_pos_in   = curr_wrap ? '0 : curr_pos_ff + 1'b1;
         short_pos_in  = short_wrap ? '0 : short_pos_ff + 1'b1;
         volt_full_in  = volt_full_ff | volt_wrap;
         curr_full_in  = curr_full_ff | curr_wrap;
         short_full_in = short_full_ff | short_wrap;
      end
   end

   // read ahead, in the cycle before, at the position the next beat will use
   always_ff @(posedge clock) begin
      if (win_we) begin
         volt_mem[volt_pos_ff]   <= s1_vs_ff;
         curr_mem[curr_pos_ff]   <= s1_cs_ff;
         short_mem[short_pos_ff] <= s1_cs_ff;
      end
      volt_rd_ff  <= volt_mem[volt_pos_in];
      curr_rd_ff  <= curr_mem[curr_pos_in];
      short_rd_ff <= short_mem[short_pos_in];
   end

   // same entry written and read in one cycle (single-entry window)
   always_ff @(posedge clock) begin
      if (reset) begin
         volt_fwd_ff  <= 1'b0;
         curr_fwd_ff  <= 1'b0;
         short_fwd_ff <= 1'b0;
      end else begin
         volt_fwd_ff  <= win_we && (volt_pos_in == volt_pos_ff);
         curr_fwd_ff  <= win_we && (curr_pos_in == curr_pos_ff);
         short_fwd_ff <= win_we && (short_pos_in == short_pos_ff);
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_v_ff <= s1_vs_ff;
      fwd_data_c_ff <= s1_cs_ff;
   end

   //---------------------------------------------------------------- fault, timer
   assign short_avg = short_sum_in / SUM_W'(SHORT_WINDOW);
   assign fault_hit = win_we && (short_avg >= SUM_W'(short_thresh_ff))
                      && (s1_vs_ff <= uv_thresh_ff);
   assign fault_in  = fault_ff | fault_hit;
   assign timer_go  = s1_valid_ff && !fault_ff && !fault_hit;

   always_comb begin
      ms_in      = ms_ff;
      sec_in     = sec_ff;
      min_in     = min_ff;
      hour_in    = hour_ff;
      timeout_in = timeout_ff;
      if (timer_go) begin
         if (s1_clr_ff) begin
            ms_in      = '0;
            sec_in     = '0;
            min_in     = '0;
            hour_in    = '0;
            timeout_in = 1'b0;
         end
         if (s1_chg_ff) begin
            if (ms_in == MS_W'(MS_PER_SEC - 1)) begin
               ms_in = '0;
               if (sec_in == SEC_W'(SEC_PER_MIN - 1)) begin
                  sec_in = '0;
                  if (min_in == MIN_W'(MIN_PER_HOUR - 1)) begin
                     min_in = '0;
                     if (hour_in != HOURS_MAX) begin
                        hour_in = hour_in + 1'b1;
                     end
                     if (hour_in >= timeout_hours_ff) begin
                        timeout_in = 1'b1;
                     end
                  end else begin
                     min_in = min_in + 1'b1;
                  end
               end else begin
                  sec_in = sec_in + 1'b1;
               end
            end else begin
               ms_in = ms_in + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volt_pos_ff   <= '0;
         curr_pos_ff   <= '0;
         short_pos_ff  <= '0;
         volt_sum_ff   <= '0;
         curr_sum_ff   <= '0;
         short_sum_ff  <= '0;
         volt_full_ff  <= 1'b0;
         curr_full_ff  <= 1'b0;
         short_full_ff <= 1'b0;
         fault_ff      <= 1'b0;
         ms_ff         <= '0;
         sec_ff        <= '0;
         min_ff        <= '0;
         hour_ff       <= '0;
         timeout_ff    <= 1'b0;
      end else begin
         volt_pos_ff   <= volt_pos_in;
         curr_pos_ff   <= curr_pos_in;
         short_pos_ff  <= short_pos_in;
         volt_sum_ff   <= volt_sum_in;
         curr_sum_ff   <= curr_sum_in;
         short_sum_ff  <= short_sum_in;
         volt_full_ff  <= volt_full_in;
         curr_full_ff  <= curr_full_in;
         short_full_ff <= short_full_in;
         fault_ff      <= fault_in;
         ms_ff         <= ms_in;
         sec_ff        <= sec_in;
         min_ff        <= min_in;
         hour_ff       <= hour_in;
         timeout_ff    <= timeout_in;
      end
   end

   //---------------------------------------------------------------- scaling
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff.valid <= s1_valid_ff;
         s2_ctl_ff.upd   <= upd;
      end
   end

   always_ff @(posedge clock) begin
      s2_avg_v_ff                <= SAMPLE_W'(volt_sum_in / SUM_W'(VOLT_WINDOW));
      s2_avg_c_ff                <= SAMPLE_W'(curr_sum_in / SUM_W'(CURR_WINDOW));
      s2_stat_ff.short_fault     <= fault_in;
      s2_stat_ff.charge_timeout  <= timeout_in;
      s2_stat_ff.elapsed_hours   <= hour_in;
      s2_stat_ff.elapsed_minutes <= min_in;
   end

   cpm_scale u_scale_v (
      .clock  (clock),
      .reset  (reset),
      .ctl_in (s2_ctl_ff),
      .avg    (s2_avg_v_ff),
      .gain   (voltage_gain_ff),
      .scaled (scaled_v),
      .coarse (coarse_v)
   );

   cpm_scale u_scale_c (
      .clock  (clock),
      .reset  (reset),
      .ctl_in (s2_ctl_ff),
      .avg    (s2_avg_c_ff),
      .gain   (current_gain_ff),
      .scaled (scaled_c),
      .coarse (coarse_c)
   );

   // status rides alongside the scaling pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SCALE_LATENCY; i++) begin
            valid_pipe_ff[i] <= 1'b0;
         end
      end else begin
         valid_pipe_ff[0] <= s2_ctl_ff.valid;
         for (int i = 1; i < SCALE_LATENCY; i++) begin
            valid_pipe_ff[i] <= valid_pipe_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      stat_pipe_ff[0] <= s2_stat_ff;
      for (int i = 1; i < SCALE_LATENCY; i++) begin
         stat_pipe_ff[i] <= stat_pipe_ff[i-1];
      end
   end

   //---------------------------------------------------------------- result buffer
   // never overflows: pending_ff counts every beat not yet taken
   assign fifo_we = valid_pipe_ff[SCALE_LATENCY-1];

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem_ff[wr_ptr_ff].voltage_mv     <= scaled_v;
         fifo_mem_ff[wr_ptr_ff].voltage_coarse <= coarse_v;
         fifo_mem_ff[wr_ptr_ff].current_ma     <= scaled_c;
         fifo_mem_ff[wr_ptr_ff].current_coarse <= coarse_c;
         fifo_mem_ff[wr_ptr_ff].stat           <= stat_pipe_ff[SCALE_LATENCY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (fifo_we) begin
            wr_ptr_ff <= (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rsp_fire) begin
            rd_ptr_ff <= (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         fifo_cnt_ff <= fifo_cnt_ff + PEND_W'(fifo_we) - PEND_W'(rsp_fire);
      end
   end

   assign fifo_head = fifo_mem_ff[rd_ptr_ff];

   assign rsp_ch.valid           = fifo_cnt_ff != '0;
   assign rsp_ch.voltage_mv      = fifo_head.voltage_mv;
   assign rsp_ch.voltage_coarse  = fifo_head.voltage_coarse;
   assign rsp_ch.current_ma      = fifo_head.current_ma;
   assign rsp_ch.current_coarse  = fifo_head.current_coarse;
   assign rsp_ch.short_fault     = fifo_head.stat.short_fault;
   assign rsp_ch.charge_timeout  = fifo_head.stat.charge_timeout;
   assign rsp_ch.elapsed_hours   = fifo_head.stat.elapsed_hours;
   assign rsp_ch.elapsed_minutes = fifo_head.stat.elapsed_minutes;

endmodule

>>> hw/rtl/cpm_checker.sv
// Port-level checker for the charger protection monitor, bound to the top level.
// Depends on cpm_pkg and charger_protection_monitor_macros.svh.
`include "charger_protection_monitor_macros.svh"

module cpm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cpm_pkg::MV_W-1:0]      rsp_voltage_mv,
   input logic [cpm_pkg::COARSE_W-1:0]  rsp_voltage_coarse,
   input logic [cpm_pkg::MV_W-1:0]      rsp_current_ma,
   input logic                          rsp_short_fault,
   input logic [cpm_pkg::MIN_W-1:0]     rsp_elapsed_minutes
);
   import cpm_pkg::*;

   logic [7:0] outstanding_ff;
   logic       fault_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         fault_seen_ff  <= 1'b0;
      end else begin
         outstanding_ff <= outstanding_ff + 8'(req_valid && req_ready)
                           - 8'(rsp_valid && rsp_ready);
         if (rsp_valid && rsp_ready && rsp_short_fault) begin
            fault_seen_ff <= 1'b1;
         end
      end
   end

   `CPM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_voltage_mv) && $stable(rsp_current_ma) && $stable(rsp_short_fault), "stalled result beat changed")

   `CPM_ASSERT(a_fault_sticky, rsp_valid && fault_seen_ff, rsp_short_fault, "short fault cleared after it was reported")

   `CPM_ASSERT(a_no_spurious, rsp_valid, outstanding_ff != '0, "result beat without an accepted request")

   `CPM_ASSERT(a_tenths, rsp_valid, (32'(rsp_voltage_coarse) * 32'(COARSE_DIV) <= 32'(rsp_voltage_mv)) && (32'(rsp_voltage_mv) < 32'(rsp_voltage_coarse) * 32'(COARSE_DIV) + 32'(COARSE_DIV)) && (rsp_elapsed_minutes < MIN_W'(MIN_PER_HOUR)), "coarse voltage or minutes out of range")

endmodule

bind charger_protection_monitor cpm_checker u_cpm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_voltage_mv      (rsp_ch.voltage_mv),
   .rsp_voltage_coarse  (rsp_ch.voltage_coarse),
   .rsp_current_ma      (rsp_ch.current_ma),
   .rsp_short_fault     (rsp_ch.short_fault),
   .rsp_elapsed_minutes (rsp_ch.elapsed_minutes)
);
